// ===== hw/rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache package
// Shared widths, codes and the scan status type of the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int ENTRIES_DEF = 16;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CNT_W = 32;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic signed [VAL_W-1:0] NO_VALUE  = -VAL_W'(1);
   localparam logic [CNT_W-1:0]        COUNT_MAX = {CNT_W{1'b1}};

   // Operation codes of the request word.
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // Status of one pass over the table.
   typedef struct packed {
      logic done;
      logic found;
      logic have_free;
   } scan_status_type;

endpackage

// ===== hw/rtl/lfu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU generic RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lfu_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU table scan
// Walks the table once per request: finds the key, the first free slot and
// the eviction victim, and writes back ranks adjusted by the last promotion.
// ----------------------------------------------------------------------------
module lfu_scan #(
   parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
   parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   parameter int NW      = $clog2(ENTRIES + 1),
   parameter int WW      = lfu_pkg::KEY_W + lfu_pkg::VAL_W + lfu_pkg::CNT_W + IW
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lfu_pkg::KEY_W-1:0]    lookup_key,
   input  logic [ENTRIES-1:0]           valid_vec,
   input  logic                         pend_vld,
   input  logic [IW-1:0]                pend_slot,
   input  logic [IW-1:0]                pend_rank,
   output logic                         rd_en,
   output logic [IW-1:0]                rd_addr,
   input  logic [WW-1:0]                rd_data,
   output logic                         wb_en,
   output logic [IW-1:0]                wb_addr,
   output logic [WW-1:0]                wb_data,
   output lfu_pkg::scan_status_type     status,
   output logic [IW-1:0]                hit_idx,
   output logic [lfu_pkg::VAL_W-1:0]    hit_value,
   output logic [lfu_pkg::CNT_W-1:0]    hit_count,
   output logic [IW-1:0]                hit_rank,
   output logic [IW-1:0]                vic_idx,
   output logic [IW-1:0]                vic_rank,
   output logic [IW-1:0]                free_idx,
   output logic [NW-1:0]                nvalid
);

   import lfu_pkg::*;

   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   logic            issuing_ff, issuing_in;
   logic [IW-1:0]   iss_idx_ff, iss_idx_in;
   logic            dat_vld_ff, dat_last_ff, done_ff;
   logic [IW-1:0]   dat_idx_ff;

   logic            found_ff, have_free_ff, have_vic_ff;
   logic [IW-1:0]   hit_idx_ff, hit_rank_ff, vic_idx_ff, vic_rank_ff, free_idx_ff;
   logic [VAL_W-1:0] hit_value_ff;
   logic [CNT_W-1:0] hit_count_ff, vic_count_ff;
   logic [NW-1:0]   nvalid_ff;

   logic [KEY_W-1:0] d_key;
   logic [VAL_W-1:0] d_value;
   logic [CNT_W-1:0] d_count;
   logic [IW-1:0]    d_rank, cor_rank;
   logic             d_valid, d_match, d_better;

   assign d_key   = rd_data[WW-1 -: KEY_W];
   assign d_value = rd_data[WW-KEY_W-1 -: VAL_W];
   assign d_count = rd_data[IW +: CNT_W];
   assign d_rank  = rd_data[IW-1:0];
   assign d_valid = dat_vld_ff && valid_vec[dat_idx_ff];

   // The previous request's promotion is applied here, on the way through.
   always_comb begin
      cor_rank = d_rank;
      if (pend_vld) begin
         if (dat_idx_ff == pend_slot) begin
            cor_rank = '0;
         end else if (d_rank < pend_rank) begin
            cor_rank = d_rank + IW'(1);
         end
      end
   end

   assign d_match  = d_valid && !found_ff && (d_key == lookup_key);
   assign d_better = !have_vic_ff || (d_count < vic_count_ff) ||
                     ((d_count == vic_count_ff) && (cor_rank > vic_rank_ff));

   always_comb begin
      issuing_in = issuing_ff;
      iss_idx_in = iss_idx_ff;
      if (start) begin
         issuing_in = 1'b1;
         iss_idx_in = '0;
      end else if (issuing_ff) begin
         if (iss_idx_ff == LAST_IDX) begin
            issuing_in = 1'b0;
         end else begin
            iss_idx_in = iss_idx_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff  <= 1'b0;
         iss_idx_ff  <= '0;
         dat_vld_ff  <= 1'b0;
         dat_last_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         issuing_ff  <= issuing_in;
         iss_idx_ff  <= iss_idx_in;
         dat_vld_ff  <= issuing_ff;
         dat_last_ff <= issuing_ff && (iss_idx_ff == LAST_IDX);
         done_ff     <= dat_vld_ff && dat_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      dat_idx_ff <= iss_idx_ff;
      if (start) begin
         found_ff     <= 1'b0;
         have_free_ff <= 1'b0;
         have_vic_ff  <= 1'b0;
         nvalid_ff    <= '0;
      end else if (dat_vld_ff) begin
         if (d_valid) begin
            nvalid_ff <= nvalid_ff + NW'(1);
            if (d_better) begin
               have_vic_ff  <= 1'b1;
               vic_idx_ff   <= dat_idx_ff;
               vic_count_ff <= d_count;
               vic_rank_ff  <= cor_rank;
            end
         end else if (!have_free_ff) begin
            have_free_ff <= 1'b1;
            free_idx_ff  <= dat_idx_ff;
         end
         if (d_match) begin
            found_ff     <= 1'b1;
            hit_idx_ff   <= dat_idx_ff;
            hit_value_ff <= d_value;
            hit_count_ff <= d_count;
            hit_rank_ff  <= cor_rank;
         end
      end
   end

   assign rd_en   = issuing_ff;
   assign rd_addr = iss_idx_ff;

   assign wb_en   = d_valid && pend_vld;
   assign wb_addr = dat_idx_ff;
   assign wb_data = {d_key, d_value, d_count, cor_rank};

   assign status.done      = done_ff;
   assign status.found     = found_ff;
   assign status.have_free = have_free_ff;

   assign hit_idx   = hit_idx_ff;
   assign hit_value = hit_value_ff;
   assign hit_count = hit_count_ff;
   assign hit_rank  = hit_rank_ff;
   assign vic_idx   = vic_idx_ff;
   assign vic_rank  = vic_rank_ff;
   assign free_idx  = free_idx_ff;
   assign nvalid    = nvalid_ff;

endmodule

// ===== hw/rtl/lfu_cache_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache table
// Key-value store with least-frequently-used replacement and a
// least-recently-used tie break, kept in one synchronous RAM.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Word
//   req_     in         req_valid / req_stall  cmd, lookup_key, write_value
//   rsp_     out        rsp_valid / rsp_stall  hit, read_value
//   csr_     in         csr_valid / csr_ready  capacity_in_use
//
// A request makes one read pass over the table RAM, one entry per cycle
// through its single read port, before its response is formed. With a
// capacity in use of zero the pass is skipped and the request goes
// straight to its response.
// Reset clears the valid bits and all control state; the RAM is not cleared.
// req_stall is high while a request is in flight. A response held by
// rsp_stall sits in the output register; the next request may already be
// accepted and scanned, and it only waits to write its result.
//
// Each RAM word holds key, value, use count and recency rank (0 = most
// recent). The rank shifts that a promotion causes are not done at once:
// the promotion is kept pending and is applied to every entry as the next
// request's pass reads it, and the adjusted word is written back in the same
// cycle. Victim choice therefore always sees the correct ranks.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
   parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [lfu_pkg::KEY_W-1:0]         req_lookup_key,
   input  logic signed [lfu_pkg::VAL_W-1:0]  req_write_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic signed [lfu_pkg::VAL_W-1:0]  rsp_read_value,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfu_pkg::CAP_W-1:0]         csr_capacity_in_use
);

   import lfu_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int NW = $clog2(ENTRIES + 1);
   localparam int WW = KEY_W + VAL_W + CNT_W + IW;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   // Control state.
   logic [1:0]        state_ff, state_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic              pend_vld_ff, pend_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Request and result payload.
   logic              cmd_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [VAL_W-1:0]  wval_ff;
   logic [NW-1:0]     cap_ff, cap_eff;
   logic              off_ff;
   logic [IW-1:0]     pend_slot_ff, pend_slot_in;
   logic [IW-1:0]     pend_rank_ff, pend_rank_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;

   logic              req_take, start, finish_go, use_free;
   logic              fin_we;
   logic [IW-1:0]     fin_addr;
   logic [WW-1:0]     fin_data;
   logic [CNT_W-1:0]  cnt_next;

   // Scan results.
   scan_status_type   status;
   logic [IW-1:0]     hit_idx, hit_rank, vic_idx, vic_rank, free_idx;
   logic [VAL_W-1:0]  hit_value;
   logic [CNT_W-1:0]  hit_count;
   logic [NW-1:0]     nvalid;

   // RAM ports.
   logic              rd_en, wb_en, ram_we;
   logic [IW-1:0]     rd_addr, wb_addr, ram_waddr;
   logic [WW-1:0]     rd_data, wb_data, ram_wdata;

   // A capacity above the table size acts as the table size.
   assign cap_eff = (32'(capacity_ff) > ENTRIES) ? NW'(ENTRIES) : NW'(capacity_ff);

   assign req_take  = req_valid && !req_stall;
   assign start     = req_take && (cap_eff != '0);
   assign finish_go = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // A new key takes a free slot only while occupancy is under the capacity.
   assign use_free  = (nvalid < cap_ff) && status.have_free;
   assign cnt_next  = (hit_count == COUNT_MAX) ? hit_count : hit_count + CNT_W'(1);

   always_comb begin
      fin_we   = finish_go && !off_ff && (status.found || (cmd_ff == CMD_PUT));
      fin_addr = vic_idx;
      fin_data = {key_ff, wval_ff, CNT_W'(1), IW'(0)};
      if (status.found) begin
         fin_addr = hit_idx;
         fin_data = {key_ff, (cmd_ff == CMD_PUT) ? wval_ff : hit_value, cnt_next, IW'(0)};
      end else if (use_free) begin
         fin_addr = free_idx;
      end
   end

   // The pass write-back and the final write never fall in the same cycle.
   assign ram_we    = fin_we || wb_en;
   assign ram_waddr = fin_we ? fin_addr : wb_addr;
   assign ram_wdata = fin_we ? fin_data : wb_data;

   always_comb begin
      state_in     = state_ff;
      capacity_in  = capacity_ff;
      valid_in     = valid_ff;
      pend_vld_in  = pend_vld_ff;
      pend_slot_in = pend_slot_ff;
      pend_rank_in = pend_rank_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;

      if (csr_valid && csr_ready) begin
         capacity_in = csr_capacity_in_use;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = (cap_eff != '0) ? S_SCAN : S_DONE;
            end
         end
         S_SCAN: begin
            if (status.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (finish_go) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_value_in = NO_VALUE;
               if (!off_ff) begin
                  // The pass consumed the old pending promotion.
                  pend_vld_in = 1'b0;
                  if (status.found) begin
                     rsp_hit_in   = 1'b1;
                     if (cmd_ff == CMD_GET) begin
                        rsp_value_in = hit_value;
                     end
                     pend_vld_in  = 1'b1;
                     pend_slot_in = hit_idx;
                     pend_rank_in = hit_rank;
                  end else if (cmd_ff == CMD_PUT) begin
                     pend_vld_in = 1'b1;
                     if (use_free) begin
                        valid_in[free_idx] = 1'b1;
                        pend_slot_in       = free_idx;
                        pend_rank_in       = IW'(nvalid);
                     end else begin
                        pend_slot_in = vic_idx;
                        pend_rank_in = vic_rank;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         capacity_ff  <= CAP_RESET;
         valid_ff     <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         valid_ff     <= valid_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff  <= req_cmd;
         key_ff  <= req_lookup_key;
         wval_ff <= req_write_value;
         cap_ff  <= cap_eff;
         off_ff  <= (cap_eff == '0);
      end
      pend_slot_ff <= pend_slot_in;
      pend_rank_ff <= pend_rank_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   lfu_scan #(
      .ENTRIES (ENTRIES),
      .IW      (IW),
      .NW      (NW),
      .WW      (WW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .lookup_key (key_ff),
      .valid_vec  (valid_ff),
      .pend_vld   (pend_vld_ff),
      .pend_slot  (pend_slot_ff),
      .pend_rank  (pend_rank_ff),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wb_en      (wb_en),
      .wb_addr    (wb_addr),
      .wb_data    (wb_data),
      .status     (status),
      .hit_idx    (hit_idx),
      .hit_value  (hit_value),
      .hit_count  (hit_count),
      .hit_rank   (hit_rank),
      .vic_idx    (vic_idx),
      .vic_rank   (vic_rank),
      .free_idx   (free_idx),
      .nvalid     (nvalid)
   );

   lfu_ram #(
      .WIDTH (WW),
      .DEPTH (ENTRIES),
      .AW    (IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall      = (state_ff != S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

// ===== hw/rtl/lfu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache checker
// Port-level assertions on the LFU cache table, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_hit,
   input  logic signed [lfu_pkg::VAL_W-1:0]  rsp_read_value
);

   import lfu_pkg::*;

   // No response is left over from before a reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A held response keeps its word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value))
      else $error("stalled response changed");

   // Every miss reports the empty value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_read_value == NO_VALUE)
      else $error("miss with a value other than the empty value");

   // An accepted request keeps the input closed in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request port open right after an accept");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (.*);

// ===== sim/lfu_cache_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache table checker
// Watches the request, response and register channels of the LFU cache
// table, keeps its own copy of the table, and compares every response word
// in order with the predicted hit flag and read value.
// ----------------------------------------------------------------------------
module lfu_cache_checker #(
   parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [lfu_pkg::KEY_W-1:0]         req_lookup_key,
   input  logic signed [lfu_pkg::VAL_W-1:0]  req_write_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_hit,
   input  logic signed [lfu_pkg::VAL_W-1:0]  rsp_read_value,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [lfu_pkg::CAP_W-1:0]         csr_capacity_in_use,
   output int                                mismatches,
   output int                                awaiting
);
   import lfu_pkg::*;

   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] read_value;
   } lookup_result_type;

   logic [CAP_W-1:0]        capacity;
   logic                    slot_valid [ENTRIES];
   logic [KEY_W-1:0]        slot_key   [ENTRIES];
   logic signed [VAL_W-1:0] slot_value [ENTRIES];
   logic [CNT_W-1:0]        slot_uses  [ENTRIES];
   int                      slot_age   [ENTRIES];
   lookup_result_type       result_q   [$];

   // Age 0 is the most recent. Valid slots younger than the old age move back.
   function automatic void make_most_recent(int s, int old_age);
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && i != s && slot_age[i] < old_age) slot_age[i]++;
      end
      slot_age[s] = 0;
   endfunction

   function automatic lookup_result_type access_table(logic cmd, logic [KEY_W-1:0] key,
                                                      logic signed [VAL_W-1:0] value);
      lookup_result_type res;
      int limit, nvalid, slot, free_slot, victim;
      bit found, have_free, have_victim;
      res.hit        = 1'b0;
      res.read_value = NO_VALUE;
      limit = int'(capacity);
      if (limit > ENTRIES) limit = ENTRIES;
      if (limit == 0) return res;

      nvalid = 0; slot = 0; free_slot = 0; victim = 0;
      found = 0; have_free = 0; have_victim = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i]) begin
            nvalid++;
            if (!found && slot_key[i] == key) begin
               found = 1;
               slot  = i;
            end
            if (!have_victim || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])) begin
               have_victim = 1;
               victim      = i;
            end
         end else if (!have_free) begin
            have_free = 1;
            free_slot = i;
         end
      end

      if (found) begin
         res.hit = 1'b1;
         if (cmd == CMD_GET) res.read_value = slot_value[slot];
         else slot_value[slot] = value;
         if (slot_uses[slot] != COUNT_MAX) slot_uses[slot]++;
         make_most_recent(slot, slot_age[slot]);
         return res;
      end

      if (cmd == CMD_PUT) begin
         if (nvalid < limit && have_free) begin
            slot = free_slot;
            slot_valid[slot] = 1'b1;
            make_most_recent(slot, nvalid);
         end else begin
            slot = victim;
            make_most_recent(slot, slot_age[slot]);
         end
         slot_key[slot]   = key;
         slot_value[slot] = value;
         slot_uses[slot]  = 1;
      end
      return res;
   endfunction

   always @(posedge clock) begin : track
      lookup_result_type want;
      if (reset) begin
         capacity = CAP_RESET;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_uses[i]  = '0;
            slot_age[i]   = 0;
         end
         result_q.delete();
      end else begin
         // A response word always belongs to an earlier request, so it is
         // checked before a request accepted at the same edge is predicted.
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) begin
               $error("response word with none expected: hit %0d read_value %0d",
                      rsp_hit, rsp_read_value);
               mismatches++;
            end else begin
               want = result_q.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, rsp_hit);
                  mismatches++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %0d, actual %0d",
                         want.read_value, rsp_read_value);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) capacity = csr_capacity_in_use;
         if (req_valid && !req_stall)
            result_q.push_back(access_table(req_cmd, req_lookup_key, req_write_value));
      end
      awaiting = result_q.size();
   end

endmodule

// ===== sim/tb_lfu_cache_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache table testbench
// Drives get and put words into the LFU cache table under several capacity
// settings and random flow control, while a checker beside the block predicts
// and compares every response word.
// ----------------------------------------------------------------------------
module tb_lfu_cache_table;
   import lfu_pkg::*;

   localparam int ENTRIES      = ENTRIES_DEF;
   // Time a request spends in the table scan, used as a settling wait.
   localparam int LATENCY      = ENTRIES + 4;
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_WORDS = 1400;
   localparam int POOL         = 24;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_cmd = CMD_GET;
   logic [KEY_W-1:0]        req_lookup_key = '0;
   logic signed [VAL_W-1:0] req_write_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_hit;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CAP_W-1:0]        csr_capacity_in_use = CAP_RESET;

   int mismatches;
   int awaiting;

   // Idle percentages of the sender and of the receiver; the stimulus moves
   // them through the three flow-control modes.
   int send_idle_pct = 11;
   int recv_idle_pct = 69;
   int quiet_cycles  = 0;

   // Keys are mostly drawn from a small pool so that gets find their keys and
   // puts fight over the slots; the pool holds both extreme keys for good.
   logic [KEY_W-1:0] key_pool [POOL];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   lfu_cache_table #(
      .ENTRIES(ENTRIES)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_lookup_key     (req_lookup_key),
      .req_write_value    (req_write_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_read_value     (rsp_read_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity_in_use(csr_capacity_in_use)
   );

   lfu_cache_checker #(
      .ENTRIES(ENTRIES)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_lookup_key     (req_lookup_key),
      .req_write_value    (req_write_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_read_value     (rsp_read_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity_in_use(csr_capacity_in_use),
      .mismatches         (mismatches),
      .awaiting           (awaiting)
   );

   // The receiver stalls at random, one decision per cycle at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   // The watchdog ends a run in which no word moves on any channel for too
   // long. Every correct quiet stretch is a scan, a stall run or a pause, all
   // far shorter than the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("lfu_cache_table: mismatch");
         $finish;
      end
   end

   // Offers one request word after a random gap and holds it until the block
   // takes it. The caller stands just after a falling edge.
   task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key,
                            input logic signed [VAL_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_cmd         = cmd;
      req_lookup_key  = key;
      req_write_value = value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Holds the sender back until every expected response word has come.
   task automatic drain_responses();
      while (awaiting != 0) @(negedge clock);
   endtask

   // The register is only written with the block idle: all responses are in
   // and a full scan time has passed.
   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      drain_responses();
      repeat (LATENCY) @(negedge clock);
      csr_valid           = 1'b1;
      csr_capacity_in_use = cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_word();
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] value;
      if ($urandom_range(0, 99) < 80) key = key_pool[$urandom_range(0, POOL - 1)];
      else key = $urandom;
      value = $urandom;
      if ($urandom_range(0, 15) == 0)
         value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      send_word($urandom_range(0, 1) ? CMD_PUT : CMD_GET, key, value);
   endtask

   function automatic logic [CAP_W-1:0] pick_capacity();
      case ($urandom_range(0, 7))
         0:       return CAP_W'(0);
         1:       return CAP_W'(1);
         2:       return CAP_W'(2);
         3:       return CAP_W'(ENTRIES);
         4:       return CAP_W'(ENTRIES + 1);
         5:       return '1;
         default: return CAP_W'($urandom_range(0, 31));
      endcase
   endfunction

   initial begin
      int sent;
      int phase_words;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL; i++) key_pool[i] = $urandom;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. With a full-size table: a miss on the empty table,
      // both extreme keys stored with both extreme values, then a put on a
      // present key, which overwrites the value and answers with no value.
      set_capacity(CAP_W'(ENTRIES));
      send_word(CMD_GET, 32'h0000_0000, 32'sd5);
      send_word(CMD_PUT, 32'h0000_0000, 32'sh7FFF_FFFF);
      send_word(CMD_PUT, 32'hFFFF_FFFF, 32'sh8000_0000);
      send_word(CMD_GET, 32'h0000_0000, 32'sd0);
      send_word(CMD_GET, 32'hFFFF_FFFF, 32'sd0);
      send_word(CMD_PUT, 32'h0000_0000, 32'sd0);
      send_word(CMD_GET, 32'h0000_0000, -32'sd1);

      // Two slots: new keys evict the least used entry.
      set_capacity(CAP_W'(2));
      send_word(CMD_PUT, 32'h5555_5555, -32'sd1);
      send_word(CMD_PUT, 32'hAAAA_AAAA, 32'sd1);
      send_word(CMD_GET, 32'h5555_5555, 32'sd0);

      // Disabled: every access misses and nothing changes.
      set_capacity(CAP_W'(0));
      send_word(CMD_GET, 32'h0000_0000, 32'sd0);
      send_word(CMD_PUT, 32'h1234_5678, 32'sd77);

      // A capacity above the table size acts as the table size; the entries
      // kept while disabled are found again.
      set_capacity('1);
      send_word(CMD_GET, 32'h0000_0000, 32'sd0);
      send_word(CMD_GET, 32'h1234_5678, 32'sd0);

      // Capacity lowered below the occupancy: each new key replaces a victim
      // and the occupancy stays where it was.
      set_capacity(CAP_W'(1));
      send_word(CMD_PUT, 32'h0F0F_0F0F, 32'sd3);
      send_word(CMD_GET, 32'h0000_0000, 32'sd0);
      send_word(CMD_PUT, 32'hF0F0_F0F0, 32'sd4);

      // Equal use counts: the least recent entry goes.
      set_capacity(CAP_W'(3));
      send_word(CMD_PUT, 32'h0000_0003, 32'sd30);
      send_word(CMD_PUT, 32'h0000_0004, 32'sd40);
      send_word(CMD_GET, 32'hF0F0_F0F0, 32'sd0);
      send_word(CMD_GET, 32'h0000_0003, 32'sd0);

      // Random part in phases of one capacity each; the flow-control mode
      // changes after each third of the words.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         if (sent >= 2 * RANDOM_WORDS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (sent >= RANDOM_WORDS / 3) begin
            send_idle_pct = 69;
            recv_idle_pct = 11;
         end
         set_capacity(pick_capacity());
         repeat (4) key_pool[$urandom_range(2, POOL - 1)] = $urandom;
         phase_words = $urandom_range(60, 140);
         repeat (phase_words) begin
            random_word();
            sent++;
            if ($urandom_range(0, 49) == 0) drain_responses();
         end
      end

      drain_responses();
      repeat (LATENCY) @(negedge clock);
      if (mismatches == 0) begin
         $display("lfu_cache_table: match");
      end else begin
         $display("lfu_cache_table: mismatch");
      end
      $finish;
   end

endmodule
